[rtl/imm_pkg.sv]
// Shared types and opcodes for the integer matrix multiply block.
// No dependencies.
package imm_pkg;
  typedef enum logic [1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_READ_C  = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } state_t;

  localparam int unsigned DATA_W = 32;
endpackage

[rtl/imm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module imm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/imm_cell.sv]
// One cell of the accumulation chain: holds a slice of A and B and a
// multiply-accumulate stage. Depends on imm_ram.
module imm_cell #(
  parameter int unsigned SDEP  = 512
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // writes into this cell's slice
  input  logic                      wa_en,
  input  logic                      wb_en,
  input  logic [$clog2(SDEP)-1:0]   waddr,
  input  logic [31:0]               wdata,
  // read addresses of this cell's slice
  input  logic [$clog2(SDEP)-1:0]   ra_addr,
  input  logic [$clog2(SDEP)-1:0]   rb_addr,
  input  logic                      term_vld,
  input  logic                      clr,
  // partial sum from the neighbor
  input  logic [31:0]               sum_in,
  output logic [31:0]               sum_out
);
  logic [31:0] a_q, b_q, prod_r, acc_r, acc_nxt;
  logic        pv_r;

  imm_ram #(.WIDTH(32), .DEPTH(SDEP)) u_a (
    .clk(clk), .we(wa_en), .waddr(waddr), .wdata(wdata), .raddr(ra_addr), .rdata(a_q)
  );
  imm_ram #(.WIDTH(32), .DEPTH(SDEP)) u_b (
    .clk(clk), .we(wb_en), .waddr(waddr), .wdata(wdata), .raddr(rb_addr), .rdata(b_q)
  );

  // product register, then local accumulate
  always_ff @(posedge clk) begin
    prod_r <= a_q * b_q;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (clr) begin
      acc_nxt = '0;
    end else if (pv_r) begin
      acc_nxt = acc_r + prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      pv_r  <= term_vld;
      acc_r <= acc_nxt;
    end
  end

  // chain sum toward the end of the row
  assign sum_out = sum_in + acc_r;
endmodule

[rtl/integer_matrix_multiply.sv]
// Top level of the integer matrix multiply block.
// Depends on imm_pkg, imm_cell, imm_ram.
//
// Input channel (in_*): opcode 0 writes A[row][col], 1 writes B[row][col],
// 2 asks for C[row][col] = sum over k of A[row][k]*B[k][col], 32-bit wrap.
// Opcode 3 and out-of-range writes are dropped; an out-of-range read
// returns zero. Result channel (out_*) carries one product per read.
// A is spread over NCELL cells by k mod NCELL, B likewise by row; each cell
// does one multiply-add per cycle while the sequencer runs. After the read
// transfer it steps through the per-cell memory reads, then the product and
// accumulate registers and the combinational chain sum, before out_valid rises.
// A write stays in the idle state. One item is worked on at a time; a read result
// sits in an output register and the block takes no item until it is
// transferred, so a stalled receiver stalls the input.
// Reset clears control state only; matrix contents are undefined until
// written and need no clearing pass.
module integer_matrix_multiply #(
  parameter int unsigned DIM   = 64,
  parameter int unsigned NCELL = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [5:0]  in_row,
  input  logic [5:0]  in_col,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_product
);
  localparam int unsigned KPC  = (DIM + NCELL - 1) / NCELL;
  localparam int unsigned SDEP = DIM * KPC;
  localparam int unsigned SW   = $clog2(SDEP);
  localparam int unsigned CW   = $clog2(NCELL) > 0 ? $clog2(NCELL) : 1;
  localparam int unsigned KW   = $clog2(KPC) > 0 ? $clog2(KPC) : 1;
  localparam int unsigned DW   = $clog2(DIM);
  localparam int unsigned DRAIN = 3;

  imm_pkg::state_t state_r, state_nxt;
  logic [KW:0]  cnt_r, cnt_nxt;
  logic [DW-1:0] rrow_r, rcol_r;
  logic          zero_r, zero_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic          clr;
  logic          term_vld;

  logic acc_in, idx_ok;
  assign acc_in = in_valid && in_ready;
  assign idx_ok = ({2'b0, in_row} < 8'(DIM)) && ({2'b0, in_col} < 8'(DIM));
  assign in_ready = (state_r == imm_pkg::ST_IDLE);
  assign out_valid = (state_r == imm_pkg::ST_OUT);
  assign out_product = prod_r;

  // write decode: element k goes to cell k mod NCELL
  logic [DW-1:0] wrow, wcol;
  assign wrow = in_row[DW-1:0];
  assign wcol = in_col[DW-1:0];

  logic [31:0] chain [NCELL+1];
  assign chain[0] = '0;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    logic          wa, wb;
    logic [SW-1:0] wad, ra, rb;
    always_comb begin
      wa  = acc_in && idx_ok && (in_opcode == imm_pkg::OP_WRITE_A)
            && (32'(wcol) % NCELL == g);
      wb  = acc_in && idx_ok && (in_opcode == imm_pkg::OP_WRITE_B)
            && (32'(wrow) % NCELL == g);
      // A slot: row*KPC + col/NCELL ; B slot: (row/NCELL)*DIM + col
      if (in_opcode == imm_pkg::OP_WRITE_A) begin
        wad = SW'(32'(wrow) * KPC + 32'(wcol) / NCELL);
      end else begin
        wad = SW'((32'(wrow) / NCELL) * DIM + 32'(wcol));
      end
      ra = SW'(32'(rrow_r) * KPC + 32'(cnt_r[KW-1:0]));
      rb = SW'(32'(cnt_r[KW-1:0]) * DIM + 32'(rcol_r));
    end
    // idle lanes past DIM multiply garbage: gate their term valid
    logic tv;
    assign tv = term_vld && ((32'(cnt_r[KW-1:0]) * NCELL + g) < DIM);
    logic tv_r;
    always_ff @(posedge clk) begin
      if (!rst_n) tv_r <= 1'b0;
      else        tv_r <= tv;
    end
    imm_cell #(.SDEP(SDEP)) u_cell (
      .clk(clk), .rst_n(rst_n), .wa_en(wa), .wb_en(wb), .waddr(wad),
      .wdata(in_value), .ra_addr(ra), .rb_addr(rb), .term_vld(tv_r),
      .clr(clr), .sum_in(chain[g]), .sum_out(chain[g+1])
    );
  end

  // read index registers
  always_ff @(posedge clk) begin
    if (acc_in) begin
      rrow_r <= in_row[DW-1:0];
      rcol_r <= in_col[DW-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    zero_nxt  = zero_r;
    prod_nxt  = prod_r;
    clr       = 1'b0;
    term_vld  = 1'b0;
    unique case (state_r)
      imm_pkg::ST_IDLE: begin
        if (acc_in && in_opcode == imm_pkg::OP_READ_C) begin
          state_nxt = imm_pkg::ST_RUN;
          cnt_nxt   = '0;
          zero_nxt  = !idx_ok;
          clr       = 1'b1;
        end
      end
      imm_pkg::ST_RUN: begin
        term_vld = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == (KW+1)'(KPC - 1)) begin
          state_nxt = imm_pkg::ST_DRAIN;
          cnt_nxt   = '0;
        end
      end
      imm_pkg::ST_DRAIN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (KW+1)'(DRAIN)) begin
          state_nxt = imm_pkg::ST_OUT;
          prod_nxt  = zero_r ? '0 : chain[NCELL];
        end
      end
      imm_pkg::ST_OUT: begin
        if (out_ready) state_nxt = imm_pkg::ST_IDLE;
      end
      default: state_nxt = imm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imm_pkg::ST_IDLE;
      cnt_r   <= '0;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      zero_r  <= zero_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // result held while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_product))
    else $error("result changed under stall");
  // no input taken while a read is in flight
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != imm_pkg::ST_IDLE |-> !in_ready)
    else $error("ready while busy");
  // a read transfer starts the sequencer
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in && in_opcode == imm_pkg::OP_READ_C |=> state_r == imm_pkg::ST_RUN)
    else $error("read not started");
endmodule

[tb/sv/integer_matrix_multiply_tb.sv]
// Testbench for integer_matrix_multiply: fill writes, a directed table, then random traffic
// checked against an in-bench matrix model. Depends on imm_pkg and the RTL.
module integer_matrix_multiply_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIM = 64;
  localparam int unsigned STALL_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [5:0]  in_row;
  logic [5:0]  in_col;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_product;

  integer_matrix_multiply #(.DIM(DIM)) dut (.*);

  // Predictor state: both matrices plus a written flag per entry
  logic [31:0] mat_a [DIM*DIM];
  logic [31:0] mat_b [DIM*DIM];
  bit          wr_a [DIM*DIM];
  bit          wr_b [DIM*DIM];
  logic [31:0] pending_products [$];
  int          errors = 0;
  int          idle_cycles;

  typedef struct {
    imm_pkg::opcode_t op;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] value;
    bit          has_exp;
    logic [31:0] exp_product;
  } stim_row_t;

  stim_row_t directed [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Row of A dotted with column of B, 32-bit wrap
  function automatic logic [31:0] dot_product(int r, int c);
    logic [31:0] acc;
    acc = '0;
    for (int k = 0; k < DIM; k++)
      acc = acc + mat_a[r*DIM + k] * mat_b[k*DIM + c];
    return acc;
  endfunction

  // Update the model on an accepted transfer and queue any product
  task automatic model_transfer(imm_pkg::opcode_t op, int r, int c, logic [31:0] v);
    bit in_range;
    in_range = (r < DIM) && (c < DIM);
    case (op)
      imm_pkg::OP_WRITE_A: if (in_range) begin
        mat_a[r*DIM + c] = v;
        wr_a[r*DIM + c] = 1'b1;
      end
      imm_pkg::OP_WRITE_B: if (in_range) begin
        mat_b[r*DIM + c] = v;
        wr_b[r*DIM + c] = 1'b1;
      end
      imm_pkg::OP_READ_C:
        pending_products.push_back(in_range ? dot_product(r, c) : 32'd0);
      default: ;
    endcase
  endtask

  // True when every element a read of (r, c) touches has been written
  function automatic bit read_ok(int r, int c);
    for (int k = 0; k < DIM; k++)
      if (!wr_a[r*DIM + k] || !wr_b[k*DIM + c]) return 1'b0;
    return 1'b1;
  endfunction

  // Rows of A and columns of B that are fully written: 0, 1, DIM-2, DIM-1
  function automatic int fill_index(int k);
    return (k < 2) ? k : DIM - 4 + k;
  endfunction

  // Drive one item, hold until the transfer, then feed the predictor
  task automatic send_item(imm_pkg::opcode_t op, logic [5:0] r, logic [5:0] c,
                           logic [31:0] v);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_row    <= r;
    in_col    <= c;
    in_value  <= v;
    do @(posedge clk); while (!in_ready);
    model_transfer(op, r, c, v);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stall per result, compare with the oldest product
  initial begin
    logic [31:0] exp_p;
    int gap;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_products.size() == 0) begin
        $error("unexpected product 0x%08h", out_product);
        errors++;
      end else begin
        exp_p = pending_products.pop_front();
        if (out_product !== exp_p) begin
          $error("product mismatch: expected 0x%08h actual 0x%08h", exp_p, out_product);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("integer_matrix_multiply test failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int r;
    int c;
    stim_row_t s;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = imm_pkg::OP_NONE;
    in_row = '0;
    in_col = '0;
    in_value = '0;
    foreach (wr_a[i]) begin
      wr_a[i] = 1'b0;
      wr_b[i] = 1'b0;
      mat_a[i] = '0;
      mat_b[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill four rows of A and four columns of B; A row 0 and B column DIM-1
    // hold the most negative value
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < DIM; k++) begin
        send_item(imm_pkg::OP_WRITE_A, 6'(fill_index(i)), 6'(k),
                  (fill_index(i) == 0) ? 32'h8000_0000 : rand_value());
        send_item(imm_pkg::OP_WRITE_B, 6'(k), 6'(fill_index(i)),
                  (fill_index(i) == DIM-1) ? 32'h8000_0000 : rand_value());
      end
    end

    // Directed table: extremes, wrap, unused opcode; blank expectations use the model
    // row 0 of A times column 63 of B: every term is 2^62, which wraps to zero
    directed.push_back('{imm_pkg::OP_READ_C, 6'd0, 6'd63, 32'h0, 1'b1, 32'h0});
    directed.push_back('{imm_pkg::OP_READ_C, 6'd63, 6'd0, 32'hffff_ffff, 1'b0, 32'h0});
    directed.push_back('{imm_pkg::OP_NONE, 6'd1, 6'd1, 32'h1234_5678, 1'b0, 32'h0});
    directed.push_back('{imm_pkg::OP_NONE, 6'd63, 6'd63, 32'hffff_ffff, 1'b0, 32'h0});
    directed.push_back('{imm_pkg::OP_WRITE_A, 6'd63, 6'd63, 32'h7fff_ffff, 1'b0, 32'h0});
    directed.push_back('{imm_pkg::OP_WRITE_B, 6'd63, 6'd63, 32'h7fff_ffff, 1'b0, 32'h0});
    directed.push_back('{imm_pkg::OP_READ_C, 6'd63, 6'd63, 32'h0, 1'b0, 32'h0});
    directed.push_back('{imm_pkg::OP_READ_C, 6'd0, 6'd0, 32'h0, 1'b0, 32'h0});
    directed.push_back('{imm_pkg::OP_READ_C, 6'd1, 6'd62, 32'h0, 1'b0, 32'h0});
    foreach (directed[i]) begin
      s = directed[i];
      send_item(s.op, s.row, s.col, s.value);
      if (s.has_exp && s.op == imm_pkg::OP_READ_C)
        pending_products[pending_products.size()-1] = s.exp_product;
    end

    // Random part: writes anywhere, reads over the filled rows and columns
    for (int n = 0; n < 1150; n++) begin
      r = $urandom_range(0, DIM-1);
      c = $urandom_range(0, DIM-1);
      case ($urandom_range(0, 9))
        0, 1, 2: send_item(imm_pkg::OP_WRITE_A, 6'(r), 6'(c), rand_value());
        3, 4, 5: send_item(imm_pkg::OP_WRITE_B, 6'(r), 6'(c), rand_value());
        6: send_item(imm_pkg::OP_NONE, 6'(r), 6'(c), $urandom);
        default: begin
          r = fill_index($urandom_range(0, 3));
          c = fill_index($urandom_range(0, 3));
          if (read_ok(r, c))
            send_item(imm_pkg::OP_READ_C, 6'(r), 6'(c), $urandom);
        end
      endcase
    end
    in_valid <= 1'b0;

    while (pending_products.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("integer_matrix_multiply test passed");
    else
      $display("integer_matrix_multiply test failed");
    $finish;
  end
endmodule

[integer_matrix_multiply.f]
rtl/imm_pkg.sv
rtl/imm_ram.sv
rtl/imm_cell.sv
rtl/integer_matrix_multiply.sv
tb/sv/integer_matrix_multiply_tb.sv
